### sv/signed_binary_to_decimal_ascii_macros.svh
// Assertion macros used by the signed_binary_to_decimal_ascii checker
`ifndef SIGNED_BINARY_TO_DECIMAL_ASCII_MACROS_SVH
`define SIGNED_BINARY_TO_DECIMAL_ASCII_MACROS_SVH

// same-cycle implication
`define SB2DA_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SB2DA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/sb2da_pkg.sv
// Shared types and constants for the signed binary to decimal ASCII converter
`default_nettype none

package sb2da_pkg;

  localparam int DATA_WIDTH_DEF = 64;

  localparam logic [5:0] CODE_MINUS = 6'd45;
  // digit codes are 0x30 | digit
  localparam logic [1:0] CODE_DIGIT_HI = 2'b11;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic clear;
    logic bit_shift;
    logic dig_shift;
  } cell_ctl_t;

endpackage

`default_nettype wire

### sv/sb2da_cell.sv
// One BCD digit cell of the shift-and-add-3 chain
`default_nettype none

module sb2da_cell (
  input  wire logic                  clk,
  input  wire sb2da_pkg::cell_ctl_t  ctl,
  input  wire logic                  bit_in,
  output logic                       bit_out,
  input  wire logic [3:0]            dig_in,
  output logic [3:0]                 dig_out
);
  import sb2da_pkg::*;

  logic [3:0] dig_r, dig_nxt;
  logic [3:0] adj;

  assign adj     = (dig_r >= 4'd5) ? dig_r + 4'd3 : dig_r;
  assign bit_out = adj[3];
  assign dig_out = dig_r;

  always_comb begin
    dig_nxt = dig_r;
    if (ctl.clear) begin
      dig_nxt = 4'd0;
    end else if (ctl.bit_shift) begin
      dig_nxt = {adj[2:0], bit_in};
    end else if (ctl.dig_shift) begin
      dig_nxt = dig_in;
    end
  end

  always_ff @(posedge clk) begin
    dig_r <= dig_nxt;
  end

endmodule

`default_nettype wire

### sv/signed_binary_to_decimal_ascii.sv
// Top level: signed integer to decimal ASCII text stream
// One value goes in per transaction; its text comes out one character per transaction, most
// significant first, a '-' ahead of negative values, no leading zeros, tlast on the final
// character. Only the low DATA_WIDTH bits of in_tdata are used. Items are handled one at a
// time: after acceptance the magnitude is shifted bit by bit into a row of BCD digit cells,
// then leading zero digits are dropped one per cycle, then the characters are sent one per
// cycle while out_tready is high.
`default_nettype none

module signed_binary_to_decimal_ascii #(
  parameter int DATA_WIDTH = sb2da_pkg::DATA_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // [63:0] value
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // [5:0] char_code, [7:6] zero
  output logic             out_tlast   // last_char
);
  import sb2da_pkg::*;

  // decimal digits of 2^(DATA_WIDTH-1); 77/256 approximates log10(2)
  localparam int NUM_DIGITS = ((DATA_WIDTH - 1) * 77) / 256 + 1;
  localparam int CNT_W      = $clog2(DATA_WIDTH + 1);
  localparam int REM_W      = $clog2(NUM_DIGITS + 1);

  state_t                  state_r, state_nxt;
  logic [DATA_WIDTH-1:0]   mag_r, mag_nxt;
  logic                    neg_r, neg_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [REM_W-1:0]        rem_r, rem_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [5:0]              out_char_r, out_char_nxt;
  logic                    out_last_r, out_last_nxt;

  logic [DATA_WIDTH-1:0]   in_val;
  logic                    slot_free;
  cell_ctl_t               ctl;
  logic [NUM_DIGITS-1:0]   bit_chain;
  logic [3:0]              dig      [NUM_DIGITS];
  logic [3:0]              dig_lo   [NUM_DIGITS];
  logic [3:0]              top_dig;

  assign in_val    = in_tdata[DATA_WIDTH-1:0];
  assign slot_free = !out_valid_r || out_tready;
  assign top_dig   = dig[NUM_DIGITS-1];

  assign bit_chain[0] = mag_r[DATA_WIDTH-1];

  for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign dig_lo[i] = 4'd0;
    end else begin : g_rest
      assign dig_lo[i] = dig[i-1];
    end

    if (i == NUM_DIGITS - 1) begin : g_top
      sb2da_cell u_cell (
        .clk     (clk),
        .ctl     (ctl),
        .bit_in  (bit_chain[i]),
        .bit_out (),
        .dig_in  (dig_lo[i]),
        .dig_out (dig[i])
      );
    end else begin : g_mid
      sb2da_cell u_cell (
        .clk     (clk),
        .ctl     (ctl),
        .bit_in  (bit_chain[i]),
        .bit_out (bit_chain[i+1]),
        .dig_in  (dig_lo[i]),
        .dig_out (dig[i])
      );
    end
  end

  always_comb begin
    state_nxt     = state_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    cnt_nxt       = cnt_r;
    rem_nxt       = rem_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    ctl           = '0;
    in_tready     = 1'b0;

    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          neg_nxt   = in_val[DATA_WIDTH-1];
          mag_nxt   = in_val[DATA_WIDTH-1] ? (~in_val) + DATA_WIDTH'(1) : in_val;
          cnt_nxt   = '0;
          rem_nxt   = REM_W'(NUM_DIGITS);
          ctl.clear = 1'b1;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        ctl.bit_shift = 1'b1;
        mag_nxt       = mag_r << 1;
        cnt_nxt       = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DATA_WIDTH - 1)) begin
          state_nxt = ST_SKIP;
        end
      end
      ST_SKIP: begin
        // drop leading zeros, keep at least one digit
        if (top_dig == 4'd0 && rem_r > REM_W'(1)) begin
          ctl.dig_shift = 1'b1;
          rem_nxt       = rem_r - REM_W'(1);
        end else begin
          state_nxt = neg_r ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CODE_MINUS;
          out_last_nxt  = 1'b0;
          state_nxt     = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = {CODE_DIGIT_HI, top_dig};
          out_last_nxt  = (rem_r == REM_W'(1));
          ctl.dig_shift = 1'b1;
          rem_nxt       = rem_r - REM_W'(1);
          if (rem_r == REM_W'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r      <= mag_nxt;
    neg_r      <= neg_nxt;
    cnt_r      <= cnt_nxt;
    rem_r      <= rem_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_char_r};
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

### sv/sb2da_checker.sv
// Port-level checks for the signed binary to decimal ASCII converter
`default_nettype none
`include "signed_binary_to_decimal_ascii_macros.svh"

module sb2da_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_tvalid,
  input wire logic       in_tready,
  input wire logic [63:0] in_tdata,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata,
  input wire logic       out_tlast
);

  logic in_fire;

  assign in_fire = in_tvalid && in_tready && (in_tdata[0] || !in_tdata[0]);

  // one value at a time: the input closes after a transaction
  `SB2DA_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_fire, !in_tready, "input reopened early")

  // a pending character that is not the last keeps the input closed
  `SB2DA_ASSERT_SAME(a_no_overlap, clk, rst_n, out_tvalid && !out_tlast, !in_tready, "overlap")

  // only '-' or a decimal digit ever leaves the block
  `SB2DA_ASSERT_SAME(a_char_legal, clk, rst_n, out_tvalid,
    out_tdata == 8'd45 || (out_tdata[7:4] == 4'd3 && out_tdata[3:0] <= 4'd9), "bad char")

  // stalled output holds
  `SB2DA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tlast), "output changed under stall")

endmodule

bind signed_binary_to_decimal_ascii sb2da_checker u_sb2da_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

`default_nettype wire

### tb/sv/signed_binary_to_decimal_ascii_tb.sv
// Self-checking testbench for the signed integer to decimal ASCII text converter
`default_nettype none

module signed_binary_to_decimal_ascii_tb;

  localparam int NUM_DIRECTED = 20;
  localparam int NUM_RANDOM   = 410;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 120;
  localparam int MAX_REPORTS  = 40;
  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_MINUS = {2'b00, sb2da_pkg::CODE_MINUS};

  typedef struct packed {
    logic [5:0] code;
    logic       last;
  } text_char_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;
  logic        out_tlast;

  text_char_t  pending_chars[$];
  int          err_count;
  int          values_sent;
  int          negatives_sent;
  int          zeros_sent;
  int          chars_checked;
  bit          idle_en;
  bit          hold_req;

  // directed values; a non-empty text is the expected output, empty means use the predictor
  logic [63:0] dir_value [NUM_DIRECTED] = '{
    64'd0,
    64'd1,
    64'hFFFF_FFFF_FFFF_FFFF,
    64'h7FFF_FFFF_FFFF_FFFF,
    64'h8000_0000_0000_0000,
    64'h8000_0000_0000_0001,
    64'd9,
    64'd10,
    -64'd9,
    -64'd10,
    64'd99,
    64'd100,
    64'd999999999999999999,
    64'd1000000000000000000,
    -64'd1000000000000000000,
    64'h5555_5555_5555_5555,
    64'hAAAA_AAAA_AAAA_AAAA,
    64'd1234567890123456789,
    -64'd4294967296,
    64'd4294967295
  };
  string dir_text [NUM_DIRECTED] = '{
    "0",
    "1",
    "-1",
    "9223372036854775807",
    "-9223372036854775808",
    "-9223372036854775807",
    "", "", "", "", "", "", "", "", "", "", "", "", "", ""
  };

  signed_binary_to_decimal_ascii dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  task automatic report(input string msg);
    if (err_count < MAX_REPORTS) $display("MISMATCH @%0t: %s", $time, msg);
    err_count++;
  endtask

  // two's complement value to its decimal text
  function automatic string decimal_text(input logic [63:0] value);
    logic [63:0] mag;
    string       text;
    string       digit;
    text  = "";
    digit = " ";
    mag   = value[63] ? (~value + 64'd1) : value;
    do begin
      digit.putc(0, ASCII_ZERO + 8'(mag % 64'd10));
      text = {digit, text};
      mag  = mag / 64'd10;
    end while (mag != 64'd0);
    if (value[63]) begin
      digit.putc(0, ASCII_MINUS);
      text = {digit, text};
    end
    return text;
  endfunction

  function automatic void push_text(input string text);
    text_char_t c;
    logic [7:0] b;
    for (int i = 0; i < text.len(); i++) begin
      b      = text[i];
      c.code = b[5:0];
      c.last = (i == text.len() - 1);
      pending_chars.push_back(c);
    end
  endfunction

  function automatic logic [63:0] random_value();
    int unsigned kind;
    int unsigned ndig;
    int          small_val;
    logic [63:0] lim;
    logic [63:0] mag;
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1, 2, 3: begin
        return {$urandom, $urandom};
      end
      4, 5, 6: begin
        // random digit count, random content
        ndig = $urandom_range(1, 19);
        lim  = 64'd1;
        repeat (ndig) lim = lim * 64'd10;
        mag = {$urandom, $urandom} % lim;
        return $urandom_range(0, 1) ? -mag : mag;
      end
      7: begin
        small_val = int'($urandom_range(0, 40)) - 20;
        return {{32{small_val[31]}}, small_val};
      end
      8: begin
        if ($urandom_range(0, 1)) return 64'h7FFF_FFFF_FFFF_FFFF - $urandom_range(0, 15);
        else return 64'h8000_0000_0000_0000 + $urandom_range(0, 15);
      end
      default: begin
        // powers of ten and their neighbors
        ndig = $urandom_range(0, 18);
        lim  = 64'd1;
        repeat (ndig) lim = lim * 64'd10;
        mag = lim + $urandom_range(0, 2) - 64'd1;
        return $urandom_range(0, 1) ? -mag : mag;
      end
    endcase
  endfunction

  task automatic send_value(input logic [63:0] value, input string text);
    @(negedge clk);
    while (idle_en && $urandom_range(0, 99) < 12) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    push_text((text == "") ? decimal_text(value) : text);
    values_sent++;
    if (value[63]) negatives_sent++;
    if (value == 64'd0) zeros_sent++;
  endtask

  task automatic wait_drained();
    while (pending_chars.size() != 0) @(posedge clk);
  endtask

  // receiver: random backpressure plus one long hold-off on request
  initial begin
    int held;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        held     = 0;
        while (held < HOLD_CYCLES) begin
          out_tready <= 1'b0;
          held++;
          @(negedge clk);
        end
      end
      out_tready <= !(idle_en && $urandom_range(0, 99) < 12);
    end
  end

  // output checker
  always @(posedge clk) begin
    text_char_t exp_c;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_chars.size() == 0) begin
        report($sformatf("unexpected character code %0d last %0b", out_tdata[5:0], out_tlast));
      end else begin
        exp_c = pending_chars.pop_front();
        chars_checked++;
        if (out_tdata[5:0] != exp_c.code)
          report($sformatf("char_code got %0d exp %0d", out_tdata[5:0], exp_c.code));
        if (out_tlast !== exp_c.last)
          report($sformatf("last_char got %0b exp %0b", out_tlast, exp_c.last));
        if (out_tdata[7:6] != 2'b00)
          report($sformatf("tdata padding got %0b exp 00", out_tdata[7:6]));
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    err_count      = 0;
    values_sent    = 0;
    negatives_sent = 0;
    zeros_sent     = 0;
    chars_checked  = 0;
    idle_en        = 1'b1;
    hold_req       = 1'b0;
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = 64'd0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NUM_DIRECTED; i++) send_value(dir_value[i], dir_text[i]);

    // sender goes quiet until all text is out
    @(negedge clk);
    in_tvalid <= 1'b0;
    wait_drained();

    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i == 100) hold_req = 1'b1;
      idle_en = !(i >= 200 && i < 280);
      if (i == 320) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        wait_drained();
      end
      send_value(random_value(), "");
    end
    @(negedge clk);
    in_tvalid <= 1'b0;
    idle_en = 1'b1;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Converted %0d values (%0d negative, %0d zero) and checked %0d characters,",
             values_sent, negatives_sent, zeros_sent, chars_checked);
    $display("with random gaps on both sides, one long output hold-off, %0d mismatches.",
             err_count);
    if (err_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

`default_nettype wire
